[hw/rtl/svm_pkg.sv]
package svm_pkg;

   localparam int MemWords = 4096;
   localparam int StackWords = 2048;
   localparam int ProcessAreaBase = 512;
   localparam int BlockWords = 32;
   localparam int MemAw = $clog2(MemWords);
   localparam int StackAw = $clog2(StackWords);
   localparam int BlkAw = $clog2(BlockWords);
   localparam logic [15:0] MainPriorityReset = 16'd100;

   localparam logic [2:0] ModeWrite = 3'd0;
   localparam logic [2:0] ModeRead = 3'd1;
   localparam logic [2:0] ModeSpawn = 3'd2;
   localparam logic [2:0] ModeSelect = 3'd3;
   localparam logic [2:0] ModeStep = 3'd4;
   localparam logic [2:0] ModeSave = 3'd5;

   localparam logic [3:0] StOk = 4'd0;
   localparam logic [3:0] StYield = 4'd1;
   localparam logic [3:0] StDied = 4'd2;
   localparam logic [3:0] StHalt = 4'd3;
   localparam logic [3:0] StBadOp = 4'd4;
   localparam logic [3:0] StBuiltin = 4'd5;
   localparam logic [3:0] StSpawned = 4'd6;
   localparam logic [3:0] StStack = 4'd7;
   localparam logic [3:0] StDivZero = 4'd8;
   localparam logic [3:0] StNoMem = 4'd9;
   localparam logic [3:0] StRead = 4'd10;

   localparam logic [7:0] OpHalt = 8'd0;
   localparam logic [7:0] OpPush = 8'd1;
   localparam logic [7:0] OpAssign = 8'd2;
   localparam logic [7:0] OpDeref = 8'd3;
   localparam logic [7:0] OpAdd = 8'd4;
   localparam logic [7:0] OpSub = 8'd5;
   localparam logic [7:0] OpMul = 8'd6;
   localparam logic [7:0] OpDiv = 8'd7;
   localparam logic [7:0] OpNeg = 8'd8;
   localparam logic [7:0] OpJump = 8'd9;
   localparam logic [7:0] OpJumpFalse = 8'd10;
   localparam logic [7:0] OpBuiltin = 8'd11;
   localparam logic [7:0] OpSpAdjust = 8'd12;
   localparam logic [7:0] OpBpMark = 8'd13;
   localparam logic [7:0] OpSpawn = 8'd14;
   localparam logic [7:0] OpReturn = 8'd15;
   localparam logic [7:0] OpYield = 8'd16;

   localparam logic [MemAw-1:0] OffId = MemAw'(0);
   localparam logic [MemAw-1:0] OffStatus = MemAw'(1);
   localparam logic [MemAw-1:0] OffIp = MemAw'(2);
   localparam logic [MemAw-1:0] OffSp = MemAw'(3);
   localparam logic [MemAw-1:0] OffExec = MemAw'(5);
   localparam logic [MemAw-1:0] OffPrio = MemAw'(6);
   localparam logic [MemAw-1:0] OffFather = MemAw'(7);
   localparam logic [MemAw-1:0] OffCaller = MemAw'(8);
   localparam logic [MemAw-1:0] OffNpar = MemAw'(9);

   typedef struct packed {
      logic [2:0] mode;
      logic [11:0] address;
      logic signed [31:0] data;
   } req_type;

   typedef struct packed {
      logic [3:0] status;
      logic signed [31:0] read_data;
      logic signed [31:0] value;
      logic signed [31:0] builtin_number;
      logic [11:0] ip_now;
      logic signed [11:0] sp_now;
   } rsp_type;

   typedef enum logic [1:0] {
      DivOpSigned = 2'b01,
      DivOpIdle = 2'b10
   } div_cmd_type;

   typedef struct packed {
      logic start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

[hw/rtl/svm_ram.sv]
module svm_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/svm_divider.sv]
module svm_divider (
   input  logic clock,
   input  logic reset,
   input  svm_pkg::div_req_type div_req,
   output svm_pkg::div_rsp_type div_rsp
);
   logic busy_ff, busy_in;
   logic [5:0] count_ff, count_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic neg_ff, neg_in;
   logic done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] shifted;

   always_comb begin
      busy_in = busy_ff;
      count_in = count_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      shifted = {rem_ff[30:0], quo_ff[31]};
      trial = {1'b0, shifted} - {1'b0, den_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         count_in = 6'd32;
         rem_in = '0;
         quo_in = div_req.dividend[31] ? (32'd0 - div_req.dividend) : div_req.dividend;
         den_in = div_req.divisor[31] ? (32'd0 - div_req.divisor) : div_req.divisor;
         neg_in = div_req.dividend[31] ^ div_req.divisor[31];
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

   property p_done_after_busy;
      @(posedge clock) disable iff (reset) div_rsp.done |-> $past(busy_ff);
   endproperty
   a_done_after_busy: assert property (p_done_after_busy) else $error("divider done without work");
endmodule

[hw/rtl/stack_vm_instruction_step.sv]
// Channel   | Ports                         | Direction | Transfer
// request   | start, busy, req_payload      | in        | start && !busy
// response  | rsp_valid, rsp_payload        | out       | rsp_valid, one cycle
// config    | csr_we, csr_data              | in        | csr_we
// An item runs to completion before the next transfer is taken: a step makes
// registered reads of the opcode, its operand words and a data word through the
// single word memory port and two stack reads, then passes the completion and result states.
// Division adds an iterative pass through the restoring divider, a spawn
// clears and fills its block word by word. Reset is synchronous and clears
// the control state; there is no clearing pass. The receiver cannot stall.
module stack_vm_instruction_step (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  svm_pkg::req_type req_payload,
   output logic rsp_valid,
   output svm_pkg::rsp_type rsp_payload,
   input  logic csr_we,
   input  logic [15:0] csr_data
);
   localparam int Aw = svm_pkg::MemAw;
   localparam int Sw = svm_pkg::StackAw;
   localparam int BlkAw_ = svm_pkg::BlkAw;

   typedef enum logic [11:0] {
      S_IDLE    = 12'b000000000001,
      S_RD1     = 12'b000000000010,
      S_OPC     = 12'b000000000100,
      S_OPND    = 12'b000000001000,
      S_STK2    = 12'b000000010000,
      S_EXEC    = 12'b000000100000,
      S_DIV     = 12'b000001000000,
      S_MEMRD   = 12'b000010000000,
      S_CLEAR   = 12'b000100000000,
      S_FILL    = 12'b001000000000,
      S_WAITPRI = 12'b010000000000,
      S_DONE    = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   svm_pkg::req_type req_ff, req_in;
   logic [15:0] prio_ff, prio_in;
   logic [Aw-1:0] ip_ff, ip_in;
   logic signed [Sw:0] sp_ff, sp_in;
   logic signed [Sw:0] bp_ff, bp_in;
   logic [11:0] cur_ff, cur_in;
   logic [Aw:0] nbb_ff, nbb_in;
   logic [7:0] op_ff, op_in;
   logic [31:0] opnd_ff, opnd_in;
   logic [31:0] top_ff, top_in;
   logic [31:0] sec_ff, sec_in;
   logic [31:0] pri_ff, pri_in;
   logic [31:0] npar_ff, npar_in;
   logic [BlkAw_:0] cnt_ff, cnt_in;
   logic [1:0] phase_ff, phase_in;
   svm_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic mem_we;
   logic [Aw-1:0] mem_wa, mem_ra;
   logic [31:0] mem_wd, mem_rd;
   logic stk_we;
   logic [Sw-1:0] stk_wa, stk_ra;
   logic [31:0] stk_wd, stk_rd;
   svm_pkg::div_req_type div_req;
   svm_pkg::div_rsp_type div_rsp;
   logic [31:0] mul_res;
   logic [31:0] alu_res;
   logic signed [Sw+1:0] adj;
   logic [Aw-1:0] nx;
   logic [Aw-1:0] blk;

   svm_ram #(.Width(32), .Depth(svm_pkg::MemWords)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
      .rd_addr(mem_ra), .rd_data(mem_rd)
   );

   svm_ram #(.Width(32), .Depth(svm_pkg::StackWords)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_addr(stk_ra), .rd_data(stk_rd)
   );

   svm_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   assign nx = ip_ff + Aw'(1);
   assign blk = nbb_ff[Aw-1:0];
   assign mul_res = sec_ff * top_ff;

   always_comb begin
      case (op_ff)
         svm_pkg::OpAdd: alu_res = sec_ff + top_ff;
         svm_pkg::OpSub: alu_res = sec_ff - top_ff;
         svm_pkg::OpMul: alu_res = mul_res;
         default: alu_res = 32'd0 - top_ff;
      endcase
   end

   assign adj = (Sw+2)'(sp_ff) + (Sw+2)'($signed(opnd_ff[Sw:0]));

   function automatic logic adj_ok(logic signed [31:0] o, logic signed [Sw:0] sp);
      logic signed [33:0] t;
      t = 34'(sp) + 34'(o);
      return (t >= -34'sd1) && (t <= 34'(svm_pkg::StackWords - 1));
   endfunction

   // Block bases are aligned to the block size, so the upper address bits
   // identify the block.
   function automatic logic in_new_block(logic [Aw-1:0] a, logic [Aw-1:0] b);
      return a[Aw-1:BlkAw_] == b[Aw-1:BlkAw_];
   endfunction

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      prio_in = csr_we ? csr_data : prio_ff;
      ip_in = ip_ff;
      sp_in = sp_ff;
      bp_in = bp_ff;
      cur_in = cur_ff;
      nbb_in = nbb_ff;
      op_in = op_ff;
      opnd_in = opnd_ff;
      top_in = top_ff;
      sec_in = sec_ff;
      pri_in = pri_ff;
      npar_in = npar_ff;
      cnt_in = cnt_ff;
      phase_in = phase_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      mem_ra = ip_ff;
      stk_we = 1'b0;
      stk_wa = sp_ff[Sw-1:0];
      stk_wd = '0;
      stk_ra = sp_ff[Sw-1:0];
      div_req = '0;
      div_req.dividend = sec_ff;
      div_req.divisor = top_ff;

      case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               req_in = req_payload;
               rsp_in = '0;
               case (req_payload.mode)
                  svm_pkg::ModeWrite: begin
                     mem_we = 1'b1;
                     mem_wa = req_payload.address[Aw-1:0];
                     mem_wd = req_payload.data;
                     state_in = S_DONE;
                  end
                  svm_pkg::ModeRead: begin
                     mem_ra = req_payload.address[Aw-1:0];
                     state_in = S_RD1;
                  end
                  svm_pkg::ModeSpawn: begin
                     if (nbb_ff + (Aw+1)'(svm_pkg::BlockWords) > (Aw+1)'(svm_pkg::MemWords)) begin
                        rsp_in.status = svm_pkg::StNoMem;
                        state_in = S_DONE;
                     end else begin
                        pri_in = 32'(prio_ff);
                        opnd_in = 32'(req_payload.address);
                        sec_in = '0;
                        npar_in = '0;
                        cnt_in = '0;
                        state_in = S_CLEAR;
                     end
                  end
                  svm_pkg::ModeSelect: begin
                     cur_in = req_payload.address;
                     mem_ra = req_payload.address[Aw-1:0] + svm_pkg::OffIp;
                     phase_in = 2'd0;
                     state_in = S_RD1;
                  end
                  svm_pkg::ModeStep: begin
                     mem_ra = ip_ff;
                     state_in = S_OPC;
                  end
                  svm_pkg::ModeSave: begin
                     mem_we = 1'b1;
                     mem_wa = req_payload.address[Aw-1:0] + svm_pkg::OffSp;
                     mem_wd = 32'(sp_ff);
                     phase_in = 2'd1;
                     state_in = S_FILL;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         S_RD1: begin
            if (req_ff.mode == svm_pkg::ModeRead) begin
               rsp_in.status = svm_pkg::StRead;
               rsp_in.read_data = mem_rd;
               state_in = S_DONE;
            end else if (phase_ff == 2'd0) begin
               ip_in = mem_rd[Aw-1:0];
               mem_ra = req_ff.address[Aw-1:0] + svm_pkg::OffSp;
               phase_in = 2'd2;
               state_in = S_MEMRD;
            end else begin
               state_in = S_DONE;
            end
         end

         S_MEMRD: begin
            if (phase_ff == 2'd2) begin
               if ($signed(mem_rd) < -32'sd1 ||
                   $signed(mem_rd) > 32'(svm_pkg::StackWords - 1)) begin
                  sp_in = -(Sw+1)'(1);
                  rsp_in.status = svm_pkg::StStack;
               end else begin
                  sp_in = (Sw+1)'(mem_rd);
               end
               state_in = S_DONE;
            end else begin
               sec_in = stk_rd;
               state_in = S_EXEC;
            end
         end

         S_OPC: begin
            op_in = mem_rd[7:0];
            mem_ra = nx;
            stk_ra = sp_ff[Sw-1:0];
            state_in = S_OPND;
         end

         S_OPND: begin
            opnd_in = mem_rd;
            top_in = stk_rd;
            stk_ra = sp_ff[Sw-1:0] - Sw'(1);
            mem_ra = nx + Aw'(1);
            state_in = S_STK2;
         end

         S_STK2: begin
            sec_in = stk_rd;
            npar_in = mem_rd;
            mem_ra = top_ff[Aw-1:0];
            if (op_ff == svm_pkg::OpSpawn) begin
               mem_ra = cur_ff[Aw-1:0] + svm_pkg::OffPrio;
               state_in = S_WAITPRI;
            end else begin
               state_in = S_EXEC;
            end
         end

         S_WAITPRI: begin
            pri_in = mem_rd;
            if (sp_ff >= (Sw+1)'(svm_pkg::StackWords - 1)) begin
               rsp_in.status = svm_pkg::StStack;
               state_in = S_DONE;
            end else if (nbb_ff + (Aw+1)'(svm_pkg::BlockWords) >
                         (Aw+1)'(svm_pkg::MemWords)) begin
               rsp_in.status = svm_pkg::StNoMem;
               state_in = S_DONE;
            end else begin
               // Operands that lie in the new block are read after it is cleared.
               if (in_new_block(cur_ff[Aw-1:0] + svm_pkg::OffPrio, blk)) begin
                  pri_in = '0;
               end
               if (in_new_block(nx, blk)) begin
                  opnd_in = '0;
               end
               if (in_new_block(nx + Aw'(1), blk)) begin
                  npar_in = '0;
               end
               sec_in = 32'(cur_ff);
               cnt_in = '0;
               state_in = S_CLEAR;
            end
         end

         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = blk + Aw'(cnt_ff[BlkAw_-1:0]);
            mem_wd = '0;
            cnt_in = cnt_ff + (BlkAw_+1)'(1);
            if (cnt_ff == (BlkAw_+1)'(svm_pkg::BlockWords - 1)) begin
               cnt_in = '0;
               phase_in = 2'd0;
               state_in = S_FILL;
            end
         end

         S_FILL: begin
            if (phase_ff == 2'd1) begin
               if (req_ff.mode == svm_pkg::ModeSave) begin
                  mem_we = 1'b1;
                  mem_wa = req_ff.address[Aw-1:0] + svm_pkg::OffExec;
                  mem_wd = 32'd1;
                  state_in = S_DONE;
               end else begin
                  mem_we = 1'b1;
                  mem_wa = cur_ff[Aw-1:0] + svm_pkg::OffExec;
                  mem_wd = 32'd1;
                  rsp_in.status = svm_pkg::StYield;
                  ip_in = nx;
                  state_in = S_DONE;
               end
            end else begin
               mem_we = 1'b1;
               cnt_in = cnt_ff + (BlkAw_+1)'(1);
               case (cnt_ff[3:0])
                  4'd0: begin mem_wa = blk + svm_pkg::OffId; mem_wd = 32'(blk); end
                  4'd1: begin mem_wa = blk + svm_pkg::OffStatus; mem_wd = 32'd1; end
                  4'd2: begin mem_wa = blk + svm_pkg::OffIp; mem_wd = opnd_ff; end
                  4'd3: begin mem_wa = blk + svm_pkg::OffSp; mem_wd = '1; end
                  4'd4: begin mem_wa = blk + svm_pkg::OffPrio; mem_wd = pri_ff; end
                  4'd5: begin mem_wa = blk + svm_pkg::OffFather; mem_wd = sec_ff; end
                  4'd6: begin mem_wa = blk + svm_pkg::OffCaller; mem_wd = sec_ff; end
                  default: begin
                     mem_wa = blk + svm_pkg::OffNpar;
                     mem_wd = npar_ff;
                     nbb_in = nbb_ff + (Aw+1)'(svm_pkg::BlockWords);
                     rsp_in.status = svm_pkg::StSpawned;
                     rsp_in.value = 32'(blk);
                     if (req_ff.mode == svm_pkg::ModeStep) begin
                        stk_we = 1'b1;
                        stk_wa = sp_ff[Sw-1:0] + Sw'(1);
                        stk_wd = 32'(blk);
                        sp_in = sp_ff + (Sw+1)'(1);
                        ip_in = nx + Aw'(2);
                     end
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_EXEC: begin
            state_in = S_DONE;
            case (op_ff)
               svm_pkg::OpHalt: begin
                  ip_in = nx;
                  rsp_in.status = svm_pkg::StHalt;
               end
               svm_pkg::OpPush: begin
                  if (sp_ff >= (Sw+1)'(svm_pkg::StackWords - 1)) begin
                     rsp_in.status = svm_pkg::StStack;
                  end else begin
                     stk_we = 1'b1;
                     stk_wa = sp_ff[Sw-1:0] + Sw'(1);
                     stk_wd = opnd_ff;
                     sp_in = sp_ff + (Sw+1)'(1);
                     ip_in = nx + Aw'(1);
                  end
               end
               svm_pkg::OpAssign: begin
                  if (sp_ff < (Sw+1)'(1)) begin
                     rsp_in.status = svm_pkg::StStack;
                  end else begin
                     mem_we = 1'b1;
                     mem_wa = top_ff[Aw-1:0];
                     mem_wd = sec_ff;
                     sp_in = sp_ff - (Sw+1)'(1);
                     ip_in = nx;
                  end
               end
               svm_pkg::OpDeref: begin
                  if (sp_ff < (Sw+1)'(0)) begin
                     rsp_in.status = svm_pkg::StStack;
                  end else begin
                     stk_we = 1'b1;
                     stk_wd = mem_rd;
                     ip_in = nx;
                  end
               end
               svm_pkg::OpAdd, svm_pkg::OpSub, svm_pkg::OpMul, svm_pkg::OpDiv: begin
                  if (sp_ff < (Sw+1)'(1)) begin
                     rsp_in.status = svm_pkg::StStack;
                  end else if (op_ff == svm_pkg::OpDiv) begin
                     if (top_ff == 32'd0) begin
                        rsp_in.status = svm_pkg::StDivZero;
                     end else begin
                        div_req.start = 1'b1;
                        state_in = S_DIV;
                     end
                  end else begin
                     stk_we = 1'b1;
                     stk_wa = sp_ff[Sw-1:0] - Sw'(1);
                     stk_wd = alu_res;
                     sp_in = sp_ff - (Sw+1)'(1);
                     ip_in = nx;
                  end
               end
               svm_pkg::OpNeg: begin
                  if (sp_ff < (Sw+1)'(0)) begin
                     rsp_in.status = svm_pkg::StStack;
                  end else begin
                     stk_we = 1'b1;
                     stk_wd = alu_res;
                     ip_in = nx;
                  end
               end
               svm_pkg::OpJump: ip_in = opnd_ff[Aw-1:0];
               svm_pkg::OpJumpFalse: begin
                  if (sp_ff < (Sw+1)'(0)) begin
                     rsp_in.status = svm_pkg::StStack;
                  end else begin
                     sp_in = sp_ff - (Sw+1)'(1);
                     ip_in = top_ff[0] ? nx + Aw'(1) : opnd_ff[Aw-1:0];
                  end
               end
               svm_pkg::OpBuiltin: begin
                  rsp_in.value = (sp_ff >= (Sw+1)'(0)) ? top_ff : 32'd0;
                  rsp_in.builtin_number = opnd_ff;
                  rsp_in.status = svm_pkg::StBuiltin;
                  ip_in = nx + Aw'(1);
               end
               svm_pkg::OpSpAdjust: begin
                  if (!adj_ok(opnd_ff, sp_ff)) begin
                     rsp_in.status = svm_pkg::StStack;
                  end else begin
                     sp_in = adj[Sw:0];
                     ip_in = nx + Aw'(1);
                  end
               end
               svm_pkg::OpBpMark: begin
                  bp_in = sp_ff;
                  ip_in = nx;
               end
               svm_pkg::OpReturn: begin
                  mem_we = 1'b1;
                  mem_wa = cur_ff[Aw-1:0] + svm_pkg::OffStatus;
                  mem_wd = 32'd2;
                  rsp_in.status = svm_pkg::StDied;
                  ip_in = nx;
               end
               svm_pkg::OpYield: begin
                  mem_we = 1'b1;
                  mem_wa = cur_ff[Aw-1:0] + svm_pkg::OffIp;
                  mem_wd = 32'(nx);
                  phase_in = 2'd3;
                  state_in = S_MEMRD;
               end
               default: begin
                  ip_in = nx;
                  rsp_in.status = svm_pkg::StBadOp;
               end
            endcase
            if (state_in == S_DONE && bp_ff == bp_in) begin
               bp_in = bp_ff;
            end
         end

         S_DIV: begin
            if (div_rsp.done) begin
               stk_we = 1'b1;
               stk_wa = sp_ff[Sw-1:0] - Sw'(1);
               stk_wd = div_rsp.quotient;
               sp_in = sp_ff - (Sw+1)'(1);
               ip_in = nx;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in.ip_now = 12'(ip_ff);
            rsp_in.sp_now = 12'(sp_ff);
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase

      if (state_ff == S_MEMRD && phase_ff == 2'd3) begin
         mem_we = 1'b1;
         mem_wa = cur_ff[Aw-1:0] + svm_pkg::OffSp;
         mem_wd = 32'(sp_ff);
         phase_in = 2'd1;
         state_in = S_FILL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         prio_ff <= svm_pkg::MainPriorityReset;
         ip_ff <= '0;
         sp_ff <= -(Sw+1)'(1);
         bp_ff <= '0;
         cur_ff <= '0;
         nbb_ff <= (Aw+1)'(svm_pkg::ProcessAreaBase);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         prio_ff <= prio_in;
         ip_ff <= ip_in;
         sp_ff <= sp_in;
         bp_ff <= bp_in;
         cur_ff <= cur_in;
         nbb_ff <= nbb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      op_ff <= op_in;
      opnd_ff <= opnd_in;
      top_ff <= top_in;
      sec_ff <= sec_in;
      pri_ff <= pri_in;
      npar_ff <= npar_in;
      cnt_ff <= cnt_in;
      phase_ff <= phase_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   property p_sp_range;
      @(posedge clock) disable iff (reset)
         (sp_ff >= -(Sw+1)'(1)) && (sp_ff <= (Sw+1)'(svm_pkg::StackWords - 1));
   endproperty
   a_sp_range: assert property (p_sp_range) else $error("stack pointer out of range");

   property p_rsp_after_done;
      @(posedge clock) disable iff (reset) rsp_valid |-> $past(state_ff == S_DONE);
   endproperty
   a_rsp_after_done: assert property (p_rsp_after_done) else $error("response without completion");

   property p_nbb_grows;
      @(posedge clock) disable iff (reset) nbb_ff >= $past(nbb_ff);
   endproperty
   a_nbb_grows: assert property (p_nbb_grows) else $error("block base went back");
endmodule

[verif/tb_stack_vm_instruction_step.sv]
`timescale 1ns / 100ps
module tb_stack_vm_instruction_step;
   import svm_pkg::*;

   localparam longint CycleLimit = 1500000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_payload;
   logic rsp_valid;
   rsp_type rsp_payload;
   logic csr_we;
   logic [15:0] csr_data;

   logic [31:0] mem_image [MemWords];
   logic [31:0] stack_image [StackWords];
   logic [11:0] pc_m;
   logic [11:0] proc_m;
   int sp_m;
   int bp_m;
   int next_base_m;
   logic [15:0] prio_m;

   rsp_type pending_results[$];
   int error_count;
   int items_sent;
   int results_checked;
   int burst_left;
   int spawn_count;
   longint cycle_count;

   stack_vm_instruction_step u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int claim_block();
      int b;
      if (next_base_m + BlockWords > MemWords) return -1;
      b = next_base_m;
      for (int k = 0; k < BlockWords; k++) mem_image[b + k] = '0;
      next_base_m = b + BlockWords;
      return b;
   endfunction

   function automatic void fill_block(logic [11:0] b, logic [31:0] entry, logic [31:0] prio,
                                      logic [31:0] father, logic [31:0] npar);
      mem_image[b + OffId] = {20'b0, b};
      mem_image[b + OffStatus] = 32'd1;
      mem_image[b + OffIp] = entry;
      mem_image[b + OffSp] = 32'hFFFF_FFFF;
      mem_image[b + 12'd4] = '0;
      mem_image[b + OffExec] = '0;
      mem_image[b + OffPrio] = prio;
      mem_image[b + OffFather] = father;
      mem_image[b + OffCaller] = father;
      mem_image[b + OffNpar] = npar;
   endfunction

   function automatic logic [3:0] exec_instruction(output logic [31:0] value,
                                                   output logic [31:0] bnum);
      logic [11:0] ip;
      logic [11:0] nx;
      logic [7:0] op;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] prio;
      logic [31:0] entry;
      logic [31:0] npar;
      longint t;
      int sp;
      int blk;
      ip = pc_m;
      sp = sp_m;
      op = mem_image[ip][7:0];
      nx = ip + 12'd1;
      value = '0;
      bnum = '0;
      case (op)
         OpHalt: begin
            pc_m = nx;
            return StHalt;
         end
         OpPush: begin
            if (sp >= StackWords - 1) return StStack;
            stack_image[sp + 1] = mem_image[nx];
            sp_m = sp + 1;
            pc_m = nx + 12'd1;
            return StOk;
         end
         OpAssign: begin
            if (sp < 1) return StStack;
            mem_image[stack_image[sp][11:0]] = stack_image[sp - 1];
            sp_m = sp - 1;
            pc_m = nx;
            return StOk;
         end
         OpDeref: begin
            if (sp < 0) return StStack;
            stack_image[sp] = mem_image[stack_image[sp][11:0]];
            pc_m = nx;
            return StOk;
         end
         OpAdd, OpSub, OpMul, OpDiv: begin
            if (sp < 1) return StStack;
            a = stack_image[sp - 1];
            b = stack_image[sp];
            if (op == OpAdd) a = a + b;
            else if (op == OpSub) a = a - b;
            else if (op == OpMul) a = a * b;
            else begin
               if (b == 0) return StDivZero;
               t = longint'($signed(a)) / longint'($signed(b));
               a = t[31:0];
            end
            stack_image[sp - 1] = a;
            sp_m = sp - 1;
            pc_m = nx;
            return StOk;
         end
         OpNeg: begin
            if (sp < 0) return StStack;
            stack_image[sp] = 32'd0 - stack_image[sp];
            pc_m = nx;
            return StOk;
         end
         OpJump: begin
            pc_m = mem_image[nx][11:0];
            return StOk;
         end
         OpJumpFalse: begin
            if (sp < 0) return StStack;
            a = stack_image[sp];
            sp_m = sp - 1;
            pc_m = a[0] ? nx + 12'd1 : mem_image[nx][11:0];
            return StOk;
         end
         OpBuiltin: begin
            value = (sp >= 0) ? stack_image[sp] : '0;
            bnum = mem_image[nx];
            pc_m = nx + 12'd1;
            return StBuiltin;
         end
         OpSpAdjust: begin
            t = longint'(sp) + longint'($signed(mem_image[nx]));
            if (t < -1 || t > StackWords - 1) return StStack;
            sp_m = int'(t);
            pc_m = nx + 12'd1;
            return StOk;
         end
         OpBpMark: begin
            bp_m = sp;
            pc_m = nx;
            return StOk;
         end
         OpSpawn: begin
            if (sp >= StackWords - 1) return StStack;
            blk = claim_block();
            if (blk < 0) return StNoMem;
            // The new block is cleared before its fields are gathered.
            entry = mem_image[nx];
            prio = mem_image[proc_m + OffPrio];
            npar = mem_image[nx + 12'd1];
            fill_block(blk[11:0], entry, prio, {20'b0, proc_m}, npar);
            stack_image[sp + 1] = blk;
            sp_m = sp + 1;
            pc_m = nx + 12'd2;
            value = blk;
            return StSpawned;
         end
         OpReturn: begin
            mem_image[proc_m + OffStatus] = 32'd2;
            pc_m = nx;
            return StDied;
         end
         OpYield: begin
            mem_image[proc_m + OffIp] = {20'b0, nx};
            mem_image[proc_m + OffSp] = 32'(sp);
            mem_image[proc_m + OffExec] = 32'd1;
            pc_m = nx;
            return StYield;
         end
         default: begin
            pc_m = nx;
            return StBadOp;
         end
      endcase
   endfunction

   function automatic rsp_type predict_step(req_type r);
      rsp_type e;
      logic [31:0] v;
      logic [31:0] bn;
      longint t;
      int blk;
      e = '0;
      v = '0;
      bn = '0;
      e.status = StOk;
      case (r.mode)
         ModeWrite: mem_image[r.address] = r.data;
         ModeRead: begin
            e.read_data = mem_image[r.address];
            e.status = StRead;
         end
         ModeSpawn: begin
            blk = claim_block();
            if (blk < 0) e.status = StNoMem;
            else begin
               fill_block(blk[11:0], {20'b0, r.address}, {16'b0, prio_m}, '0, '0);
               v = blk;
               e.status = StSpawned;
            end
         end
         ModeSelect: begin
            proc_m = r.address;
            pc_m = mem_image[r.address + OffIp][11:0];
            t = longint'($signed(mem_image[r.address + OffSp]));
            if (t < -1 || t > StackWords - 1) begin
               sp_m = -1;
               e.status = StStack;
            end else sp_m = int'(t);
         end
         ModeStep: e.status = exec_instruction(v, bn);
         ModeSave: begin
            mem_image[r.address + OffSp] = 32'(sp_m);
            mem_image[r.address + OffExec] = 32'd1;
         end
         default: ;
      endcase
      e.value = v;
      e.builtin_number = bn;
      e.ip_now = pc_m;
      e.sp_now = sp_m[11:0];
      return e;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (error_count < 40)
         $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles with %0d results pending", cycle_count,
                  pending_results.size());
         $display("tb_stack_vm_instruction_step failed");
         $finish;
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) report_mismatch("unexpected transfer", '0, '0);
         else begin
            e = pending_results.pop_front();
            results_checked++;
            if (rsp_payload.status !== e.status)
               report_mismatch("status", rsp_payload.status, e.status);
            if (rsp_payload.read_data !== e.read_data)
               report_mismatch("read_data", rsp_payload.read_data, e.read_data);
            if (rsp_payload.value !== e.value)
               report_mismatch("value", rsp_payload.value, e.value);
            if (rsp_payload.builtin_number !== e.builtin_number)
               report_mismatch("builtin_number", rsp_payload.builtin_number, e.builtin_number);
            if (rsp_payload.ip_now !== e.ip_now)
               report_mismatch("ip_now", rsp_payload.ip_now, e.ip_now);
            if (rsp_payload.sp_now !== e.sp_now)
               report_mismatch("sp_now", rsp_payload.sp_now, e.sp_now);
         end
      end
   end

   task automatic send_item(logic [2:0] mode, logic [11:0] addr, logic [31:0] data);
      req_type r;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 12);
      end
      r.mode = mode;
      r.address = addr;
      r.data = data;
      start <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(predict_step(r));
      items_sent++;
      burst_left--;
   endtask

   task automatic drain();
      start <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_priority(logic [15:0] v);
      csr_we <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      prio_m = v;
   endtask

   task automatic run_op(logic [7:0] op, logic [31:0] operand);
      logic [11:0] at;
      at = pc_m;
      send_item(ModeWrite, at, {$urandom_range(0, 1) ? 24'h0 : 24'($urandom), op});
      send_item(ModeWrite, at + 12'd1, operand);
      send_item(ModeStep, '0, '0);
   endtask

   task automatic test_fill_memory();
      for (int a = 0; a < MemWords; a++)
         send_item(ModeWrite, a[11:0], {24'($urandom), OpPush});
   endtask

   task automatic test_stack_limits();
      repeat (StackWords + 1) send_item(ModeStep, '0, '0);
      run_op(OpSpAdjust, -32'sd2048);
      run_op(OpSpAdjust, -32'sd1);
      run_op(OpAdd, '0);
      run_op(OpBuiltin, 32'h7FFF_FFFF);
      run_op(OpBpMark, '0);
      run_op(OpSpAdjust, 32'd2048);
      run_op(OpSpAdjust, 32'd2048);
      run_op(OpSpAdjust, -32'sd2040);
   endtask

   task automatic test_opcodes();
      run_op(OpPush, 32'h8000_0000);
      run_op(OpPush, 32'hFFFF_FFFF);
      run_op(OpDiv, '0);
      run_op(OpPush, '0);
      run_op(OpDiv, '0);
      run_op(OpPush, 32'd7);
      run_op(OpPush, -32'sd2);
      run_op(OpDiv, '0);
      for (int op = OpHalt; op <= OpYield; op++)
         run_op(op[7:0], $urandom_range(0, 1) ? 32'($urandom_range(0, 4095)) : $urandom);
      run_op(8'hFF, '0);
      run_op(8'd17, '0);
   endtask

   task automatic test_modes();
      send_item(3'd6, 12'hFFF, 32'hFFFF_FFFF);
      send_item(3'd7, '0, '0);
      send_item(ModeWrite, 12'hFFF, 32'h7FFF_FFFF);
      send_item(ModeWrite, 12'h000, 32'h8000_0000);
      send_item(ModeRead, 12'hFFF, '0);
      send_item(ModeRead, 12'h000, '0);
      send_item(ModeWrite, 12'd103, 32'd5000);
      send_item(ModeSelect, 12'd100, '0);
      send_item(ModeSave, 12'd100, '0);
      send_item(ModeRead, 12'd103, '0);
   endtask

   task automatic test_priority(logic [15:0] v);
      int blk;
      drain();
      write_priority(v);
      blk = next_base_m;
      send_item(ModeSpawn, 12'($urandom), '0);
      if (blk + BlockWords <= MemWords) begin
         send_item(ModeSelect, blk[11:0], '0);
         send_item(ModeRead, 12'(blk + OffPrio), '0);
      end
      spawn_count++;
      drain();
   endtask

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 3))
         0, 1: return {($urandom_range(0, 2) == 0) ? 24'($urandom) : 24'h0,
                       8'($urandom_range(0, 16))};
         2: return 32'($signed($urandom_range(0, 12)) - 4);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_random(int n);
      int pick;
      int blocks;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) send_item(ModeStep, 12'($urandom), $urandom);
         else if (pick < 75)
            send_item(ModeWrite, $urandom_range(0, 1) ? pc_m + 12'($urandom_range(0, 3))
                                                      : 12'($urandom), random_word());
         else if (pick < 83) send_item(ModeRead, 12'($urandom), $urandom);
         else if (pick < 89) begin
            blocks = (next_base_m - ProcessAreaBase) / BlockWords;
            if (blocks > 0 && $urandom_range(0, 2) != 0)
               send_item(ModeSelect,
                         12'(ProcessAreaBase + BlockWords * $urandom_range(0, blocks - 1)), '0);
            else send_item(ModeSelect, 12'($urandom), $urandom);
         end else if (pick < 94) send_item(ModeSave, 12'($urandom), $urandom);
         else if (pick < 96) begin
            send_item(ModeSpawn, 12'($urandom), $urandom);
            spawn_count++;
         end else send_item(3'($urandom_range(6, 7)), 12'($urandom), $urandom);
      end
   endtask

   task automatic test_exhaustion();
      while (next_base_m + BlockWords <= MemWords) send_item(ModeSpawn, 12'($urandom), '0);
      send_item(ModeSpawn, 12'hFFF, '0);
      send_item(ModeSpawn, '0, '0);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_data = '0;
      error_count = 0;
      items_sent = 0;
      results_checked = 0;
      burst_left = 0;
      spawn_count = 0;
      cycle_count = 0;
      pc_m = '0;
      sp_m = -1;
      bp_m = 0;
      proc_m = '0;
      next_base_m = ProcessAreaBase;
      prio_m = MainPriorityReset;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_memory();
      test_stack_limits();
      test_opcodes();
      test_modes();
      test_priority(16'd0);
      test_priority(16'hFFFF);
      test_random(950);
      test_priority(16'($urandom));
      test_random(950);
      test_exhaustion();
      test_priority(MainPriorityReset);
      drain();

      $display("Ran %0d transfers in, %0d results checked, %0d main spawns issued.",
               items_sent, results_checked, spawn_count);
      $display("Covered the stack limits, every opcode, all modes and block exhaustion.");
      if (error_count == 0 && pending_results.size() == 0)
         $display("tb_stack_vm_instruction_step passed");
      else
         $display("tb_stack_vm_instruction_step failed");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/svm_pkg.sv
hw/rtl/svm_ram.sv
hw/rtl/svm_divider.sv
hw/rtl/stack_vm_instruction_step.sv
verif/tb_stack_vm_instruction_step.sv
